FILE: rtl/bfbd_pkg.sv
// ----------------------------------------------------------------------------
// bfbd_pkg
// Shared types and constants of the byte FIFO with address-guarded burst drain.
// ----------------------------------------------------------------------------
package bfbd_pkg;

	// Default storage depth and drain burst limit
	localparam int BUF_DEPTH_DEF = 1024;
	localparam int MAX_BURST_DEF = 64;

	// Input opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Input beat
	typedef struct packed {
		logic        opcode;
		logic [7:0]  data_byte;
		logic [63:0] request_address;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_burst;
	} out_beat_t;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_en;
		logic load_burst;
		logic rd_issue;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic go;
		logic credit_ok;
		logic burst_last;
	} sts_t;

endpackage

FILE: rtl/bfbd_ram.sv
// ----------------------------------------------------------------------------
// bfbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bfbd_ctrl.sv
// ----------------------------------------------------------------------------
// bfbd_ctrl
// Controller: accepts write and drain beats, sequences the burst reads.
// ----------------------------------------------------------------------------
module bfbd_ctrl
	import bfbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic opcode,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.load_burst = 1'b0;
		cmd.rd_issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && opcode == OP_WRITE) begin
					cmd.wr_en = 1'b1;
				end else if (in_valid && opcode == OP_DRAIN && sts.go) begin
					cmd.load_burst = 1'b1;
					state_d        = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// issue one read per cycle while the output queue has room
				if (sts.credit_ok) begin
					cmd.rd_issue = 1'b1;
					if (sts.burst_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/bfbd_dp.sv
// ----------------------------------------------------------------------------
// bfbd_dp
// Datapath: byte store, pointers, fill count, address match, output queue.
// ----------------------------------------------------------------------------
module bfbd_dp
	import bfbd_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  in_beat_t    in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data
);

	localparam int PW   = $clog2(BUF_DEPTH);
	localparam int CW   = $clog2(BUF_DEPTH + 1);
	localparam int RMW  = $clog2(MAX_BURST + 1);
	localparam int CMPW = (CW > RMW) ? CW : RMW;

	logic [63:0]   station_q;
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic [RMW-1:0] rem_q;
	logic [CMPW-1:0] count_ext, burst_ext;
	logic          not_full, do_write;
	logic          infl_q, infl_last_q;
	logic [7:0]    rdata;
	logic [1:0]    occ_q;
	out_beat_t     e0_q, e1_q, new_beat;
	logic          push, pop;

	// Station address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
		end else if (cfg_we) begin
			station_q <= cfg_wdata;
		end
	end

	// Drop writes when full; size the burst
	assign not_full  = count_q != CW'(BUF_DEPTH);
	assign do_write  = cmd.wr_en && not_full;
	assign count_ext = CMPW'(count_q);
	assign burst_ext = (count_ext < CMPW'(MAX_BURST)) ? count_ext : CMPW'(MAX_BURST);

	// Pointers, fill count and remaining burst length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (do_write) begin
				wptr_q  <= (wptr_q == PW'(BUF_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (cmd.rd_issue) begin
				rptr_q  <= (rptr_q == PW'(BUF_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_burst) begin
				rem_q <= RMW'(burst_ext);
			end else if (cmd.rd_issue) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	bfbd_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (wptr_q),
		.wdata (in_data.data_byte),
		.re    (cmd.rd_issue),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	// Track the read in flight and its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= 1'b0;
		end else begin
			infl_q <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			infl_last_q <= (rem_q == RMW'(1));
		end
	end

	// Two-entry output queue
	assign push      = infl_q;
	assign pop       = out_valid && out_ready;
	assign new_beat  = '{out_byte: rdata, last_of_burst: infl_last_q};
	assign out_valid = occ_q != 2'd0;
	assign out_data  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (occ_q == 2'd0) begin
					e0_q <= new_beat;
				end else begin
					e1_q <= new_beat;
				end
			end
			2'b01: begin
				e0_q <= e1_q;
			end
			2'b11: begin
				if (occ_q == 2'd1) begin
					e0_q <= new_beat;
				end else begin
					e0_q <= e1_q;
					e1_q <= new_beat;
				end
			end
			default: begin
				e0_q <= e0_q;
			end
		endcase
	end

	// Status to the controller
	assign sts.go         = (in_data.request_address == station_q) && (count_q != '0);
	assign sts.credit_ok  = ({1'b0, occ_q} + {2'b00, infl_q}) < (3'd2 + {2'b00, pop});
	assign sts.burst_last = rem_q == RMW'(1);

endmodule

FILE: rtl/byte_fifo_burst_drain.sv
// ----------------------------------------------------------------------------
// byte_fifo_burst_drain
// Circular byte FIFO drained in bursts on a station address match.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready input. opcode 0 appends data_byte (dropped when full);
//           opcode 1 is a drain request carrying request_address.
//   out_* : valid/ready output, one beat per drained byte, oldest first,
//           last_of_burst set on the final beat of a burst.
//   cfg_we/cfg_wdata : station address, loaded while cfg_we is high, no wait.
// Throughput: one write beat per cycle while idle. A matching drain request
//   streams min(fill, MAX_BURST) bytes at one byte per cycle while the output
//   queue has room, paced by the single RAM read port. The input is not ready
//   while a burst is being read out.
// A request that does not match, or finds the FIFO empty, produces nothing.
// Reset clears pointers, fill count, station address and the output queue.
// When the receiver stalls, a two-entry output queue holds drained bytes and
//   the reads pause until it has room; nothing is lost.
// ----------------------------------------------------------------------------
module byte_fifo_burst_drain
	import bfbd_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data
);

	cmd_t cmd;
	sts_t sts;

	bfbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_data.opcode),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	bfbd_dp #(
		.BUF_DEPTH (BUF_DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	// no burst read while the input side is open
	a_issue_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !in_ready)
		else $error("read issued while accepting input");

	// every issued read reaches the output queue
	a_issue_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> ##2 out_valid)
		else $error("issued read did not reach output");

	// the last read of a burst returns the controller to accepting input
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue && sts.burst_last) |=> in_ready)
		else $error("controller did not return to idle after burst");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the byte FIFO with address-guarded burst drain. Write beats
// and drain requests go in through the valid/ready input. A scoreboard keeps
// its own copy of the FIFO and the station address, works out the drained
// bytes of each accepted request and compares every output beat with them.
// Directed beats come first, then random write groups closed by drain
// requests, then a drain down to empty.
// ----------------------------------------------------------------------------
module tb_top;
	import bfbd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 340;
	localparam int IDLE_PERCENT   = 16;

	// Scoreboard: shadow FIFO plus the queue of bytes due at the output
	class drain_scoreboard;
		logic [7:0]  store [BUF_DEPTH_DEF];
		int unsigned wr_ptr;
		int unsigned rd_ptr;
		int unsigned fill;
		logic [63:0] station;
		out_beat_t   due [$];
		int unsigned fails;

		function new();
			wr_ptr  = 0;
			rd_ptr  = 0;
			fill    = 0;
			station = '0;
			fails   = 0;
		endfunction

		function void set_station(input logic [63:0] addr);
			station = addr;
		endfunction

		// Apply one accepted input beat and queue the bytes it drains
		function void note_input(input in_beat_t b);
			int unsigned burst;
			out_beat_t   r;
			if (b.opcode == OP_WRITE) begin
				// drop the byte when full
				if (fill < BUF_DEPTH_DEF) begin
					store[wr_ptr] = b.data_byte;
					wr_ptr = (wr_ptr + 1) % BUF_DEPTH_DEF;
					fill++;
				end
				return;
			end
			if (b.request_address != station)
				return;
			burst = (fill < MAX_BURST_DEF) ? fill : MAX_BURST_DEF;
			for (int unsigned k = 0; k < burst; k++) begin
				r.out_byte      = store[rd_ptr];
				r.last_of_burst = (k + 1 == burst);
				due.push_back(r);
				rd_ptr = (rd_ptr + 1) % BUF_DEPTH_DEF;
			end
			fill -= burst;
		endfunction

		// Compare one output beat with the oldest byte due
		function void check_output(input out_beat_t got);
			out_beat_t want;
			if (due.size() == 0) begin
				$error("unexpected beat: out_byte %02h last_of_burst %0b",
					got.out_byte, got.last_of_burst);
				fails++;
				return;
			end
			want = due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				fails++;
			end
			if (got.last_of_burst !== want.last_of_burst) begin
				$error("last_of_burst: expected %0b, actual %0b",
					want.last_of_burst, got.last_of_burst);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_beat_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_beat_t   out_data;

	drain_scoreboard sb = new();
	int unsigned     items_sent   = 0;
	int unsigned     stuck_cycles = 0;
	bit              no_idle      = 1'b0;

	byte_fifo_burst_drain #(
		.BUF_DEPTH(BUF_DEPTH_DEF),
		.MAX_BURST(MAX_BURST_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the receiver at random unless in a no-idle stretch
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Check every output beat taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_output(out_data);
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("byte_fifo_burst_drain: mismatch");
			$finish;
		end
	end

	// Offer one beat, idling at random first, and hold it until taken
	task automatic send_beat(input in_beat_t b);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
		items_sent++;
	endtask

	task automatic push_byte(input logic [7:0] value);
		in_beat_t b;
		b.opcode          = OP_WRITE;
		b.data_byte       = value;
		b.request_address = {$urandom, $urandom};
		send_beat(b);
	endtask

	task automatic request_drain(input logic [63:0] addr);
		in_beat_t b;
		b.opcode          = OP_DRAIN;
		b.data_byte       = 8'($urandom_range(255));
		b.request_address = addr;
		send_beat(b);
	endtask

	// Drop valid, wait for every due byte, then let a silent request finish
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_station(input logic [63:0] addr);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_station(addr);
	endtask

	initial begin
		int unsigned target;
		int unsigned first_random;
		int unsigned last_cfg;
		int unsigned sel;
		int unsigned n;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: station address still at its reset value of zero
		request_drain(64'd0);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h01);
		request_drain(64'hFFFF_FFFF_FFFF_FFFF);
		request_drain(64'h8000_0000_0000_0000);
		request_drain(64'd0);
		request_drain(64'd0);

		load_station(64'hFFFF_FFFF_FFFF_FFFF);
		push_byte(8'h5A);
		request_drain(64'd0);
		request_drain(64'hFFFF_FFFF_FFFF_FFFF);

		load_station(64'h0123_4567_89AB_CDEF);
		push_byte(8'hC3);
		push_byte(8'h3C);
		push_byte(8'h7E);
		request_drain(64'h0123_4567_89AB_CDEE);
		request_drain(64'h0123_4567_89AB_CDEF);

		// Random: write groups closed by a drain, with some noise requests
		first_random = items_sent;
		last_cfg     = items_sent;
		target       = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			no_idle = (items_sent - first_random >= 120) && (items_sent - first_random < 220);
			if (items_sent - last_cfg >= 60) begin
				case ($urandom_range(3))
					0:       load_station(64'd0);
					1:       load_station(64'hFFFF_FFFF_FFFF_FFFF);
					2:       load_station({$urandom_range(1) ? 32'hAAAA_AAAA : 32'h5555_5555,
							$urandom});
					default: load_station({$urandom, $urandom});
				endcase
				last_cfg = items_sent;
			end
			sel = $urandom_range(99);
			if (sel < 75) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(65, 120) : $urandom_range(0, 12);
				repeat (n) push_byte(8'($urandom_range(255)));
				request_drain(sb.station);
			end else if (sel < 88) begin
				request_drain(sb.station ^ (64'd1 << $urandom_range(63)));
			end else if (sel < 94) begin
				request_drain({$urandom, $urandom});
			end else begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
			end
		end
		no_idle = 1'b0;

		// Drain down to empty, then ask once more on the empty FIFO
		request_drain(~sb.station);
		while (sb.fill > 0)
			request_drain(sb.station);
		request_drain(sb.station);

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.fails == 0)
			$display("byte_fifo_burst_drain: match");
		else
			$display("byte_fifo_burst_drain: mismatch");
		$finish;
	end

endmodule
